>>> src/rvdec_pkg.sv
// Shared types and codes for the RV64I to internal operation decoder.
package rvdec_pkg;

    localparam int FETCH_BITS = 48;

    // Major opcode, instruction bits 6:2.
    localparam logic [4:0] MAJ_LOAD      = 5'h00;
    localparam logic [4:0] MAJ_OP_IMM    = 5'h04;
    localparam logic [4:0] MAJ_AUIPC     = 5'h05;
    localparam logic [4:0] MAJ_OP_IMM_32 = 5'h06;
    localparam logic [4:0] MAJ_STORE     = 5'h08;
    localparam logic [4:0] MAJ_OP        = 5'h0C;
    localparam logic [4:0] MAJ_LUI       = 5'h0D;
    localparam logic [4:0] MAJ_OP_32     = 5'h0E;
    localparam logic [4:0] MAJ_BRANCH    = 5'h18;
    localparam logic [4:0] MAJ_JALR      = 5'h19;
    localparam logic [4:0] MAJ_JAL       = 5'h1B;

    // Internal operations.
    localparam logic [4:0] OPN_NONE  = 5'd0;
    localparam logic [4:0] OPN_MOVB  = 5'd1;
    localparam logic [4:0] OPN_MOVX2 = 5'd8;
    localparam logic [4:0] OPN_BREQ  = 5'd9;
    localparam logic [4:0] OPN_BRNE  = 5'd10;
    localparam logic [4:0] OPN_BRLT  = 5'd11;
    localparam logic [4:0] OPN_BRGE  = 5'd12;
    localparam logic [4:0] OPN_BRBI  = 5'd13;
    localparam logic [4:0] OPN_BRHE  = 5'd14;
    localparam logic [4:0] OPN_BRA   = 5'd15;
    localparam logic [4:0] OPN_BSR   = 5'd16;
    localparam logic [4:0] OPN_ADD   = 5'd17;
    localparam logic [4:0] OPN_SHLDQ = 5'd18;
    localparam logic [4:0] OPN_XOR   = 5'd19;
    localparam logic [4:0] OPN_SHADQ = 5'd20;
    localparam logic [4:0] OPN_OR    = 5'd21;
    localparam logic [4:0] OPN_AND   = 5'd22;
    localparam logic [4:0] OPN_SUB   = 5'd23;
    localparam logic [4:0] OPN_SHARQ = 5'd24;
    localparam logic [4:0] OPN_SHLRQ = 5'd25;
    localparam logic [4:0] OPN_MOV   = 5'd26;
    localparam logic [4:0] OPN_ADDSL = 5'd27;
    localparam logic [4:0] OPN_SHLD  = 5'd28;
    localparam logic [4:0] OPN_SHAD  = 5'd29;
    localparam logic [4:0] OPN_SUBSL = 5'd30;

    // Operand formats.
    localparam logic [3:0] FMT_NONE          = 4'd0;
    localparam logic [3:0] FMT_LD_REG_DISP1R = 4'd1;
    localparam logic [3:0] FMT_REG_ST_DISP1  = 4'd2;
    localparam logic [3:0] FMT_REG_REG_PCD   = 4'd3;
    localparam logic [3:0] FMT_LD_REG_DISP1  = 4'd4;
    localparam logic [3:0] FMT_PC_DISP       = 4'd5;
    localparam logic [3:0] FMT_REG_PC_DISP   = 4'd6;
    localparam logic [3:0] FMT_REG_IMM_REG   = 4'd7;
    localparam logic [3:0] FMT_REG_REG_REG   = 4'd8;
    localparam logic [3:0] FMT_IMM_REG       = 4'd9;

    // funct3 codes that the decode looks at by name.
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRX  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_SD   = 3'd3;
    localparam logic [2:0] F3_SX2  = 3'd7;

    localparam logic [4:0] RISCV_X0     = 5'd0;
    localparam logic [4:0] SPECIAL_REGS = 5'd6;
    localparam logic [5:0] SPECIAL_BASE = 6'd32;

    typedef struct packed {
        logic [15:0]           insn_low;
        logic [15:0]           insn_high;
        logic [FETCH_BITS-1:0] fetch_address;
    } request_t;

    typedef struct packed {
        logic [4:0]         operation_id;
        logic [3:0]         format_id;
        logic [5:0]         dest_reg;
        logic [5:0]         source_reg;
        logic [5:0]         third_reg;
        logic signed [63:0] immediate;
        logic               is_control_flow;
        logic               decode_error;
    } result_t;

    // x0..x5 land on the special register codes above the general ones.
    function automatic logic [5:0] map_reg(input logic [4:0] r);
        logic [5:0] m;
        if (r < SPECIAL_REGS)
        begin
            m = SPECIAL_BASE + {1'b0, r};
        end
        else
        begin
            m = {1'b0, r};
        end
        return m;
    endfunction

endpackage

>>> src/rvdec_decode.sv
// Combinational decode of one instruction word into an internal operation.
module rvdec_decode #(
    parameter int ADDR_BITS = 48
) (
    input  rvdec_pkg::request_t request,
    output rvdec_pkg::result_t  result
);
    import rvdec_pkg::*;

    logic [31:0]           w;
    logic [4:0]            major;
    logic [2:0]            f3;
    logic                  b30;
    logic                  rd_zero;
    logic [5:0]            rd;
    logic [5:0]            rs1;
    logic [5:0]            rs2;
    logic [63:0]           i_imm;
    logic [63:0]           s_imm;
    logic [63:0]           b_imm;
    logic [63:0]           j_imm;
    logic [63:0]           u_imm;
    logic [63:0]           neg_sh;
    logic [FETCH_BITS-1:0] addr_masked;
    logic [63:0]           auipc_sum;

    assign w       = {request.insn_high, request.insn_low};
    assign major   = w[6:2];
    assign f3      = w[14:12];
    assign b30     = w[30];
    assign rd_zero = (w[11:7] == RISCV_X0);
    assign rd      = map_reg(w[11:7]);
    assign rs1     = map_reg(w[19:15]);
    assign rs2     = map_reg(w[24:20]);

    assign i_imm  = {{52{w[31]}}, w[31:20]};
    assign s_imm  = {{52{w[31]}}, w[31:25], w[11:7]};
    // Branch and jump displacements are kept in halfword units.
    assign b_imm  = {{52{w[31]}}, w[31], w[7], w[30:25], w[11:8]};
    assign j_imm  = {{44{w[31]}}, w[31], w[19:12], w[20], w[30:21]};
    assign u_imm  = {{32{w[31]}}, w[31:12], 12'b0};
    assign neg_sh = 64'd0 - {58'd0, w[25:20]};

    // Address bits at and above ADDR_BITS do not take part in AUIPC.
    always_comb
    begin
        for (int i = 0; i < FETCH_BITS; i++)
        begin
            addr_masked[i] = (i < ADDR_BITS) ? request.fetch_address[i] : 1'b0;
        end
    end

    assign auipc_sum = {{(64-FETCH_BITS){1'b0}}, addr_masked} + u_imm + 64'd4;

    always_comb
    begin
        result = '0;
        case (major)
            MAJ_LOAD:
            begin
                result.dest_reg     = rd;
                result.source_reg   = rs1;
                result.immediate    = i_imm;
                result.operation_id = OPN_MOVB + {2'b0, f3};
                result.format_id    = FMT_LD_REG_DISP1R;
            end
            MAJ_STORE:
            begin
                result.dest_reg   = rs1;
                result.source_reg = rs2;
                result.immediate  = s_imm;
                if (f3 <= F3_SD)
                begin
                    result.operation_id = OPN_MOVB + {2'b0, f3};
                    result.format_id    = FMT_REG_ST_DISP1;
                end
                else if (f3 == F3_SX2)
                begin
                    result.operation_id = OPN_MOVX2;
                    result.format_id    = FMT_REG_ST_DISP1;
                end
            end
            MAJ_BRANCH:
            begin
                result.is_control_flow = 1'b1;
                result.dest_reg        = rs1;
                result.source_reg      = rs2;
                result.immediate       = b_imm;
                case (f3)
                    F3_BEQ:  result.operation_id = OPN_BREQ;
                    F3_BNE:  result.operation_id = OPN_BRNE;
                    F3_BLT:  result.operation_id = OPN_BRLT;
                    F3_BGE:  result.operation_id = OPN_BRGE;
                    F3_BLTU: result.operation_id = OPN_BRBI;
                    F3_BGEU: result.operation_id = OPN_BRHE;
                    default: result.operation_id = OPN_NONE;
                endcase
                if (result.operation_id != OPN_NONE)
                begin
                    result.format_id = FMT_REG_REG_PCD;
                end
            end
            MAJ_JALR:
            begin
                result.is_control_flow = 1'b1;
                result.immediate       = i_imm;
                if (rd_zero)
                begin
                    result.dest_reg     = rs1;
                    result.operation_id = OPN_BRA;
                    result.format_id    = FMT_LD_REG_DISP1;
                end
                else
                begin
                    result.dest_reg     = rd;
                    result.source_reg   = rs1;
                    result.operation_id = OPN_BSR;
                    result.format_id    = FMT_LD_REG_DISP1R;
                end
            end
            MAJ_JAL:
            begin
                result.is_control_flow = 1'b1;
                result.immediate       = j_imm;
                if (rd_zero)
                begin
                    result.operation_id = OPN_BRA;
                    result.format_id    = FMT_PC_DISP;
                end
                else
                begin
                    result.dest_reg     = rd;
                    result.operation_id = OPN_BSR;
                    result.format_id    = FMT_REG_PC_DISP;
                end
            end
            MAJ_OP_IMM:
            begin
                result.dest_reg   = rd;
                result.source_reg = rs1;
                result.immediate  = i_imm;
                case (f3)
                    F3_ADD:  result.operation_id = OPN_ADD;
                    F3_SLL:  result.operation_id = OPN_SHLDQ;
                    F3_XOR:  result.operation_id = OPN_XOR;
                    F3_OR:   result.operation_id = OPN_OR;
                    F3_AND:  result.operation_id = OPN_AND;
                    F3_SRX:
                    begin
                        result.immediate    = neg_sh;
                        result.operation_id = b30 ? OPN_SHADQ : OPN_SHLDQ;
                    end
                    default: result.operation_id = OPN_NONE;
                endcase
                if (result.operation_id != OPN_NONE)
                begin
                    result.format_id = FMT_REG_IMM_REG;
                end
            end
            MAJ_OP, MAJ_OP_32:
            begin
                result.dest_reg   = rd;
                result.source_reg = rs1;
                result.third_reg  = rs2;
                case (f3)
                    F3_ADD:
                    begin
                        if (major == MAJ_OP)
                        begin
                            result.operation_id = b30 ? OPN_SUB : OPN_ADD;
                        end
                        else
                        begin
                            result.operation_id = b30 ? OPN_SUBSL : OPN_ADDSL;
                        end
                    end
                    F3_SLL:  result.operation_id = OPN_SHLDQ;
                    F3_XOR:  result.operation_id = OPN_XOR;
                    F3_OR:   result.operation_id = OPN_OR;
                    F3_AND:  result.operation_id = OPN_AND;
                    F3_SRX:
                    begin
                        result.immediate    = neg_sh;
                        result.operation_id = b30 ? OPN_SHARQ : OPN_SHLRQ;
                    end
                    default: result.operation_id = OPN_NONE;
                endcase
                if (result.operation_id != OPN_NONE)
                begin
                    result.format_id = FMT_REG_REG_REG;
                end
            end
            MAJ_AUIPC:
            begin
                result.dest_reg     = rd;
                result.immediate    = auipc_sum;
                result.operation_id = OPN_MOV;
                result.format_id    = FMT_IMM_REG;
            end
            MAJ_LUI:
            begin
                result.dest_reg     = rd;
                result.immediate    = u_imm;
                result.operation_id = OPN_MOV;
                result.format_id    = FMT_IMM_REG;
            end
            MAJ_OP_IMM_32:
            begin
                result.dest_reg   = rd;
                result.source_reg = rs1;
                result.immediate  = i_imm;
                case (f3)
                    F3_ADD:  result.operation_id = OPN_ADDSL;
                    F3_SLL:  result.operation_id = OPN_SHLD;
                    F3_SRX:
                    begin
                        result.immediate    = neg_sh;
                        result.operation_id = b30 ? OPN_SHAD : OPN_SHLD;
                    end
                    default: result.operation_id = OPN_NONE;
                endcase
                if (result.operation_id != OPN_NONE)
                begin
                    result.format_id = FMT_REG_IMM_REG;
                end
            end
            default:
            begin
                result.decode_error = 1'b1;
            end
        endcase
    end

endmodule

>>> src/rv64i_to_internal_op_decoder_core.sv
// Top level of the RV64I to internal operation decoder.
//
// A request (two instruction halves and the fetch address) is taken at
// every rising edge where start is high and busy is low. busy never rises,
// so one request can be taken in every cycle.
// The request is captured in an input register, decoded by one pass of
// combinational logic and captured again in the result register. The result
// appears on the result port with done high once it has passed both registers,
// for one cycle only; the receiver has no way to stall it.
// Throughput is one request per cycle; latency is set by the two registers.
// The longest path runs through the AUIPC address add, a three-operand 64-bit sum.
// Unknown major opcodes give decode_error high and all other fields zero.
// Reset clears the valid flags of both registers, so requests in flight are
// dropped and no done strobe follows; the payload registers are not reset.
module rv64i_to_internal_op_decoder_core #(
    parameter int ADDR_BITS = 48
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  rvdec_pkg::request_t request,
    output logic                done,
    output rvdec_pkg::result_t  result
);
    import rvdec_pkg::*;

    request_t request_reg;
    logic     request_valid_reg;
    result_t  result_next;
    result_t  result_reg;
    logic     done_reg;

    assign busy = 1'b0;

    rvdec_decode #(
        .ADDR_BITS(ADDR_BITS)
    ) u_decode (
        .request(request_reg),
        .result (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_valid_reg <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            request_valid_reg <= start && !busy;
            done_reg          <= request_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            request_reg <= request;
        end
        if (request_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/rvdec_checker.sv
// Port-level checks for the decoder core, bound onto the top level.
module rvdec_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input rvdec_pkg::request_t request,
    input logic                done,
    input rvdec_pkg::result_t  result
);
    import rvdec_pkg::*;

    // Every request taken gives a result once it has passed the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("accepted request produced no result");

    // No result appears unless a request was taken and passed the input and result registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 2))
        else $error("result strobe without a matching request");

    // A decode error leaves every other field clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.decode_error) |->
            (result.operation_id == OPN_NONE && result.format_id == FMT_NONE &&
             result.dest_reg == 6'd0 && result.source_reg == 6'd0 &&
             result.third_reg == 6'd0 && result.immediate == 64'sd0 &&
             !result.is_control_flow))
        else $error("decode error with nonzero fields");

    // An assigned operation always carries an operand format.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.operation_id != OPN_NONE) |-> (result.format_id != FMT_NONE))
        else $error("operation without format");

    // Control flow never uses a third register and is never an error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.is_control_flow) |->
            (!result.decode_error && result.third_reg == 6'd0))
        else $error("control flow result with bad fields");

endmodule

bind rv64i_to_internal_op_decoder_core rvdec_checker u_rvdec_checker (.*);

>>> dv/tb_rv64i_to_internal_op_decoder_core.sv
// Self-checking testbench for the RV64I to internal operation decoder core.
module tb_rv64i_to_internal_op_decoder_core;

    timeunit 1ns;
    timeprecision 1ps;

    import rvdec_pkg::*;

    localparam int ADDR_BITS       = 48;
    localparam int RANDOM_PER_PASS = 340;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int MAX_PRINTED     = 100;

    // funct3 names that the package does not define.
    localparam logic [2:0] F3_SLT     = 3'd2;
    localparam logic [2:0] F3_BR_NONE = 3'd2;
    localparam logic [2:0] F3_ST_NONE = 3'd4;

    localparam int SENDER_IDLE_PCT [4] = '{0, 78, 0, 21};

    localparam logic [4:0] VALID_MAJORS [11] = '{
        MAJ_LOAD, MAJ_OP_IMM, MAJ_AUIPC, MAJ_OP_IMM_32, MAJ_STORE, MAJ_OP,
        MAJ_LUI, MAJ_OP_32, MAJ_BRANCH, MAJ_JALR, MAJ_JAL
    };

    localparam result_t ZERO_WORD_RESULT = '{
        operation_id: OPN_MOVB, format_id: FMT_LD_REG_DISP1R,
        dest_reg: SPECIAL_BASE, source_reg: SPECIAL_BASE, third_reg: 6'd0,
        immediate: 64'sd0, is_control_flow: 1'b0, decode_error: 1'b0
    };

    localparam result_t BAD_MAJOR_RESULT = '{
        operation_id: OPN_NONE, format_id: FMT_NONE,
        dest_reg: 6'd0, source_reg: 6'd0, third_reg: 6'd0,
        immediate: 64'sd0, is_control_flow: 1'b0, decode_error: 1'b1
    };

    localparam result_t LUI_TOP_RESULT = '{
        operation_id: OPN_MOV, format_id: FMT_IMM_REG,
        dest_reg: SPECIAL_BASE + 6'd1, source_reg: 6'd0, third_reg: 6'd0,
        immediate: 64'hFFFF_FFFF_FFFF_F000, is_control_flow: 1'b0, decode_error: 1'b0
    };

    typedef struct {
        logic [31:0]           word;
        logic [FETCH_BITS-1:0] addr;
        bit                    typed;
        result_t               want;
    } stim_row_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    request_t request;
    logic     done;
    result_t  result;

    result_t     pending_decodes [$];
    stim_row_t   directed_rows [$];
    int unsigned mismatch_count;
    int unsigned cycle_count;

    rv64i_to_internal_op_decoder_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [5:0] reg_code(input logic [4:0] r);
        return (r < 5'd6) ? (6'd32 + {1'b0, r}) : {1'b0, r};
    endfunction

    // Expected decode of one request.
    function automatic result_t decode_rv64i(input request_t req);
        logic [31:0] w;
        logic [63:0] addr;
        logic [63:0] i_imm;
        logic [63:0] s_imm;
        logic [63:0] b_imm;
        logic [63:0] j_imm;
        logic [63:0] u_imm;
        logic [63:0] neg_sh;
        logic [5:0]  rd;
        logic [5:0]  rs1;
        logic [5:0]  rs2;
        logic [2:0]  f3;
        logic        alt;
        logic [4:0]  alu_op;
        result_t     r;
        w      = {req.insn_high, req.insn_low};
        addr   = 64'(req.fetch_address);
        if (ADDR_BITS < 64)
        begin
            addr = addr & ((64'd1 << ADDR_BITS) - 64'd1);
        end
        rd     = reg_code(w[11:7]);
        rs1    = reg_code(w[19:15]);
        rs2    = reg_code(w[24:20]);
        f3     = w[14:12];
        alt    = w[30];
        i_imm  = {{52{w[31]}}, w[31:20]};
        s_imm  = {{52{w[31]}}, w[31:25], w[11:7]};
        b_imm  = {{52{w[31]}}, w[31], w[7], w[30:25], w[11:8]};
        j_imm  = {{44{w[31]}}, w[31], w[19:12], w[20], w[30:21]};
        u_imm  = {{32{w[31]}}, w[31:12], 12'b0};
        neg_sh = 64'd0 - {58'd0, w[25:20]};
        case (f3)
            F3_ADD:  alu_op = OPN_ADD;
            F3_SLL:  alu_op = OPN_SHLDQ;
            F3_XOR:  alu_op = OPN_XOR;
            F3_OR:   alu_op = OPN_OR;
            F3_AND:  alu_op = OPN_AND;
            default: alu_op = OPN_NONE;
        endcase
        r = '0;
        case (w[6:2])
            MAJ_LOAD:
            begin
                r.dest_reg     = rd;
                r.source_reg   = rs1;
                r.immediate    = i_imm;
                r.operation_id = OPN_MOVB + {2'b0, f3};
                r.format_id    = FMT_LD_REG_DISP1R;
            end
            MAJ_STORE:
            begin
                r.dest_reg   = rs1;
                r.source_reg = rs2;
                r.immediate  = s_imm;
                if (f3 <= F3_SD)
                begin
                    r.operation_id = OPN_MOVB + {2'b0, f3};
                    r.format_id    = FMT_REG_ST_DISP1;
                end
                else if (f3 == F3_SX2)
                begin
                    r.operation_id = OPN_MOVX2;
                    r.format_id    = FMT_REG_ST_DISP1;
                end
            end
            MAJ_BRANCH:
            begin
                r.is_control_flow = 1'b1;
                r.dest_reg        = rs1;
                r.source_reg      = rs2;
                r.immediate       = b_imm;
                case (f3)
                    F3_BEQ:  r.operation_id = OPN_BREQ;
                    F3_BNE:  r.operation_id = OPN_BRNE;
                    F3_BLT:  r.operation_id = OPN_BRLT;
                    F3_BGE:  r.operation_id = OPN_BRGE;
                    F3_BLTU: r.operation_id = OPN_BRBI;
                    F3_BGEU: r.operation_id = OPN_BRHE;
                    default: r.operation_id = OPN_NONE;
                endcase
                r.format_id = (r.operation_id != OPN_NONE) ? FMT_REG_REG_PCD : FMT_NONE;
            end
            MAJ_JALR:
            begin
                r.is_control_flow = 1'b1;
                r.immediate       = i_imm;
                if (w[11:7] == RISCV_X0)
                begin
                    r.dest_reg     = rs1;
                    r.operation_id = OPN_BRA;
                    r.format_id    = FMT_LD_REG_DISP1;
                end
                else
                begin
                    r.dest_reg     = rd;
                    r.source_reg   = rs1;
                    r.operation_id = OPN_BSR;
                    r.format_id    = FMT_LD_REG_DISP1R;
                end
            end
            MAJ_JAL:
            begin
                r.is_control_flow = 1'b1;
                r.immediate       = j_imm;
                if (w[11:7] == RISCV_X0)
                begin
                    r.operation_id = OPN_BRA;
                    r.format_id    = FMT_PC_DISP;
                end
                else
                begin
                    r.dest_reg     = rd;
                    r.operation_id = OPN_BSR;
                    r.format_id    = FMT_REG_PC_DISP;
                end
            end
            MAJ_OP_IMM:
            begin
                r.dest_reg   = rd;
                r.source_reg = rs1;
                r.immediate  = i_imm;
                if (f3 == F3_SRX)
                begin
                    r.immediate    = neg_sh;
                    r.operation_id = alt ? OPN_SHADQ : OPN_SHLDQ;
                end
                else
                begin
                    r.operation_id = alu_op;
                end
                r.format_id = (r.operation_id != OPN_NONE) ? FMT_REG_IMM_REG : FMT_NONE;
            end
            MAJ_OP, MAJ_OP_32:
            begin
                r.dest_reg   = rd;
                r.source_reg = rs1;
                r.third_reg  = rs2;
                if (f3 == F3_ADD)
                begin
                    if (w[6:2] == MAJ_OP)
                    begin
                        r.operation_id = alt ? OPN_SUB : OPN_ADD;
                    end
                    else
                    begin
                        r.operation_id = alt ? OPN_SUBSL : OPN_ADDSL;
                    end
                end
                else if (f3 == F3_SRX)
                begin
                    // Register right shifts still carry the negated I-immediate shift count.
                    r.immediate    = neg_sh;
                    r.operation_id = alt ? OPN_SHARQ : OPN_SHLRQ;
                end
                else
                begin
                    r.operation_id = alu_op;
                end
                r.format_id = (r.operation_id != OPN_NONE) ? FMT_REG_REG_REG : FMT_NONE;
            end
            MAJ_AUIPC:
            begin
                r.dest_reg     = rd;
                r.immediate    = addr + u_imm + 64'd4;
                r.operation_id = OPN_MOV;
                r.format_id    = FMT_IMM_REG;
            end
            MAJ_LUI:
            begin
                r.dest_reg     = rd;
                r.immediate    = u_imm;
                r.operation_id = OPN_MOV;
                r.format_id    = FMT_IMM_REG;
            end
            MAJ_OP_IMM_32:
            begin
                r.dest_reg   = rd;
                r.source_reg = rs1;
                r.immediate  = i_imm;
                if (f3 == F3_ADD)
                begin
                    r.operation_id = OPN_ADDSL;
                end
                else if (f3 == F3_SLL)
                begin
                    r.operation_id = OPN_SHLD;
                end
                else if (f3 == F3_SRX)
                begin
                    r.immediate    = neg_sh;
                    r.operation_id = alt ? OPN_SHAD : OPN_SHLD;
                end
                r.format_id = (r.operation_id != OPN_NONE) ? FMT_REG_IMM_REG : FMT_NONE;
            end
            default:
            begin
                r.decode_error = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] enc_i(input logic [4:0] maj, input logic [2:0] f3,
                                          input logic [4:0] rd, input logic [4:0] rs1,
                                          input logic [11:0] imm);
        return {imm, rs1, f3, rd, maj, 2'b11};
    endfunction

    function automatic logic [31:0] enc_s(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [11:0] imm);
        return {imm[11:5], rs2, rs1, f3, imm[4:0], MAJ_STORE, 2'b11};
    endfunction

    function automatic logic [31:0] enc_b(input logic [2:0] f3, input logic [4:0] rs1,
                                          input logic [4:0] rs2, input logic [12:0] imm);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], MAJ_BRANCH, 2'b11};
    endfunction

    function automatic logic [31:0] enc_j(input logic [4:0] rd, input logic [20:0] imm);
        return {imm[20], imm[10:1], imm[11], imm[19:12], rd, MAJ_JAL, 2'b11};
    endfunction

    function automatic logic [31:0] enc_u(input logic [4:0] maj, input logic [4:0] rd,
                                          input logic [19:0] imm);
        return {imm, rd, maj, 2'b11};
    endfunction

    function automatic logic [31:0] enc_r(input logic [4:0] maj, input logic [2:0] f3,
                                          input logic alt, input logic [4:0] rd,
                                          input logic [4:0] rs1, input logic [4:0] rs2);
        return {1'b0, alt, 5'b0, rs2, rs1, f3, rd, maj, 2'b11};
    endfunction

    task automatic add_row(input logic [31:0] word, input logic [FETCH_BITS-1:0] addr,
                           input bit typed, input result_t want);
        stim_row_t row;
        row.word  = word;
        row.addr  = addr;
        row.typed = typed;
        row.want  = want;
        directed_rows.push_back(row);
    endtask

    // Mostly well-formed words over the handled majors, with low register numbers
    // favored so that the special register mapping and rd of x0 come up often.
    function automatic request_t random_request();
        logic [31:0] w;
        request_t    req;
        w = $urandom;
        if ($urandom_range(99) < 80)
        begin
            w[6:2] = VALID_MAJORS[$urandom_range(10)];
            if ($urandom_range(3) == 0)
            begin
                w[11:7] = 5'($urandom_range(5));
            end
            if ($urandom_range(3) == 0)
            begin
                w[19:15] = 5'($urandom_range(5));
            end
            if ($urandom_range(3) == 0)
            begin
                w[24:20] = 5'($urandom_range(5));
            end
        end
        req.insn_low  = w[15:0];
        req.insn_high = w[31:16];
        case ($urandom_range(7))
            0:       req.fetch_address = '0;
            1:       req.fetch_address = '1;
            default: req.fetch_address = FETCH_BITS'({$urandom, $urandom});
        endcase
        return req;
    endfunction

    task automatic send_request(input request_t req, input bit typed, input result_t want);
        @(negedge clk);
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_decodes.push_back(typed ? want : decode_rv64i(req));
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start <= 1'b0;
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (mismatch_count < MAX_PRINTED)
        begin
            $display("ERROR cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
        end
        mismatch_count++;
    endtask

    task automatic check_decode(input result_t got, input result_t want);
        if (got.operation_id !== want.operation_id)
            flag_mismatch("operation_id", 64'(got.operation_id), 64'(want.operation_id));
        if (got.format_id !== want.format_id)
            flag_mismatch("format_id", 64'(got.format_id), 64'(want.format_id));
        if (got.dest_reg !== want.dest_reg)
            flag_mismatch("dest_reg", 64'(got.dest_reg), 64'(want.dest_reg));
        if (got.source_reg !== want.source_reg)
            flag_mismatch("source_reg", 64'(got.source_reg), 64'(want.source_reg));
        if (got.third_reg !== want.third_reg)
            flag_mismatch("third_reg", 64'(got.third_reg), 64'(want.third_reg));
        if (got.immediate !== want.immediate)
            flag_mismatch("immediate", got.immediate, want.immediate);
        if (got.is_control_flow !== want.is_control_flow)
            flag_mismatch("is_control_flow", 64'(got.is_control_flow),
                          64'(want.is_control_flow));
        if (got.decode_error !== want.decode_error)
            flag_mismatch("decode_error", 64'(got.decode_error), 64'(want.decode_error));
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && done)
        begin
            if (pending_decodes.size() == 0)
            begin
                flag_mismatch("result with no request pending", 64'(result.immediate), '0);
            end
            else
            begin
                want = pending_decodes.pop_front();
                check_decode(result, want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        request_t req;
        mismatch_count = 0;
        cycle_count    = 0;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;

        add_row(32'h0000_0000, '0, 1'b1, ZERO_WORD_RESULT);
        add_row(32'hFFFF_FFFF, '1, 1'b1, BAD_MAJOR_RESULT);
        add_row(32'h0000_100F, '1, 1'b1, BAD_MAJOR_RESULT);
        add_row(enc_u(MAJ_LUI, 5'd1, 20'hFFFFF), '0, 1'b1, LUI_TOP_RESULT);
        add_row(enc_i(MAJ_LOAD, F3_SX2, 5'd31, 5'd5, 12'h800), '1, 1'b0, '0);
        add_row(enc_i(MAJ_LOAD, F3_SD, 5'd6, RISCV_X0, 12'h7FF), '0, 1'b0, '0);
        add_row(enc_s(F3_SD, 5'd2, 5'd31, 12'h800), '0, 1'b0, '0);
        add_row(enc_s(F3_ST_NONE, 5'd31, RISCV_X0, 12'h7FF), '0, 1'b0, '0);
        add_row(enc_s(F3_SX2, 5'd1, 5'd3, 12'h001), '0, 1'b0, '0);
        add_row(enc_b(F3_BEQ, RISCV_X0, 5'd5, 13'h1000), '0, 1'b0, '0);
        add_row(enc_b(F3_BR_NONE, 5'd7, 5'd8, 13'h0FFE), '0, 1'b0, '0);
        add_row(enc_b(F3_BGEU, 5'd31, 5'd30, 13'h0002), '0, 1'b0, '0);
        // Jumps that link to x0 turn into plain branches.
        add_row(enc_i(MAJ_JALR, F3_ADD, RISCV_X0, 5'd1, 12'hFFF), '0, 1'b0, '0);
        add_row(enc_i(MAJ_JALR, F3_ADD, 5'd1, 5'd31, 12'h800), '0, 1'b0, '0);
        add_row(enc_j(RISCV_X0, 21'h0F_FFFE), '0, 1'b0, '0);
        add_row(enc_j(5'd1, 21'h10_0000), '0, 1'b0, '0);
        add_row(enc_i(MAJ_OP_IMM, F3_SRX, 5'd5, 5'd6, {2'b01, 4'd0, 6'd63}), '0, 1'b0, '0);
        add_row(enc_i(MAJ_OP_IMM, F3_SRX, RISCV_X0, RISCV_X0, 12'h000), '0, 1'b0, '0);
        add_row(enc_i(MAJ_OP_IMM, F3_SLL, 5'd9, 5'd10, 12'hFFF), '0, 1'b0, '0);
        add_row(enc_i(MAJ_OP_IMM, F3_SLT, 5'd11, 5'd12, 12'h123), '0, 1'b0, '0);
        add_row(enc_r(MAJ_OP, F3_ADD, 1'b1, 5'd1, 5'd2, 5'd3), '0, 1'b0, '0);
        add_row(enc_r(MAJ_OP, F3_SRX, 1'b1, 5'd31, 5'd31, 5'd31), '0, 1'b0, '0);
        add_row(enc_r(MAJ_OP_32, F3_ADD, 1'b1, 5'd4, 5'd5, 5'd6), '0, 1'b0, '0);
        add_row(enc_r(MAJ_OP_32, F3_SLL, 1'b0, 5'd7, 5'd8, 5'd9), '0, 1'b0, '0);
        add_row(enc_i(MAJ_OP_IMM_32, F3_SRX, 5'd13, 5'd14, {2'b01, 4'd0, 6'd31}), '0, 1'b0, '0);
        add_row(enc_u(MAJ_AUIPC, 5'd1, 20'hFFFFF), '1, 1'b0, '0);
        add_row(enc_u(MAJ_AUIPC, RISCV_X0, 20'h7FFFF), '0, 1'b0, '0);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            req.insn_low      = directed_rows[i].word[15:0];
            req.insn_high     = directed_rows[i].word[31:16];
            req.fetch_address = directed_rows[i].addr;
            send_request(req, directed_rows[i].typed, directed_rows[i].want);
        end

        foreach (SENDER_IDLE_PCT[pass])
        begin
            repeat (RANDOM_PER_PASS)
            begin
                while ($urandom_range(99) < SENDER_IDLE_PCT[pass])
                begin
                    idle_cycle();
                end
                send_request(random_request(), 1'b0, '0);
            end
        end
        idle_cycle();

        while (pending_decodes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
